FILE: design/klock_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klock_pkg: shared constants for the keypad code lock
// Key codes, mode selectors, status codes and the default code length.
// ----------------------------------------------------------------------------
package klock_pkg;

  localparam int MAX_CODE_LEN_DEF = 15;

  localparam logic [7:0] KEY_CLEAR = 8'h46;  // 'F'
  localparam logic [7:0] KEY_MODE  = 8'h45;  // 'E'
  localparam logic [7:0] KEY_ENTER = 8'h44;  // 'D'

  localparam logic [1:0] OP_UNLOCK = 2'd0;
  localparam logic [1:0] OP_VERIFY = 2'd1;
  localparam logic [1:0] OP_ENTER  = 2'd2;

  localparam logic [2:0] ST_CLEARED = 3'd0;
  localparam logic [2:0] ST_CLOSED  = 3'd1;
  localparam logic [2:0] ST_OPEN    = 3'd2;
  localparam logic [2:0] ST_ALARM   = 3'd3;
  localparam logic [2:0] ST_MODE    = 3'd4;
  localparam logic [2:0] ST_NEW     = 3'd5;
  localparam logic [2:0] ST_SAME    = 3'd6;
  localparam logic [2:0] ST_CHANGED = 3'd7;

endpackage

FILE: design/klock_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klock_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module klock_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/keypad_code_lock_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_code_lock_unit: keypad combination lock with three modes
// Matches keys against a stored code (unlock / verify) and buffers new codes
// (enter), committing them into the code memory on 'D' or a key on a full buffer.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------
//  in      | in_valid / in_stall  | op[1:0], key[7:0]
//  out     | out_valid / out_stall| status[2:0]
//
//  Clear, mode, enter-buffer, counted-miss and unused-selector beats load the
//  output register from the response state; a match beat first passes the
//  lookup state (one code memory read). A commit first copies the entry
//  buffer memory into the code memory, one entry per cycle.
//  Reset (rst, synchronous) zeroes all counters and lengths; no memory
//  clearing pass is needed since only entries below code_length are read.
//  One beat is in work at a time; a beat may be accepted while the previous
//  status waits in the output register, and work stalls only at the hand-off.
// ----------------------------------------------------------------------------
module keypad_code_lock_unit import klock_pkg::*; #(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  input  logic [7:0] key,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status
);

  localparam int AW = $clog2(MAX_CODE_LEN);
  localparam int LW = $clog2(MAX_CODE_LEN + 1);
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_CODE_LEN);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_COPY,
    S_RESP
  } state_t;

  state_t         state;
  logic [1:0]     op_r;
  logic [7:0]     key_r;
  logic [2:0]     res;

  // per-mode counters and lengths
  logic [LW-1:0]  u_pos, u_miss, v_pos, v_miss;
  logic [LW-1:0]  code_len, ent_len;

  // commit copy pipeline
  logic [LW-1:0]  rd_idx;
  logic [AW-1:0]  wr_idx;
  logic           wr_pend;

  // memory ports
  logic           code_we;
  logic [7:0]     code_rdata;
  logic           ent_we;
  logic [7:0]     ent_rdata;

  // selected counters and their next values
  logic [1:0]     cur_op;
  logic [LW-1:0]  sel_pos, sel_miss, pos_inc, step_miss;
  logic [LW:0]    miss_inc;
  logic           alarm, hit, last;
  logic [2:0]     step_res, done_st;
  logic           in_acc, ent_store;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Counters follow the live selector while idle, the held one afterwards.
  assign cur_op   = (state == S_IDLE) ? op : op_r;
  assign sel_pos  = (cur_op == OP_VERIFY) ? v_pos : u_pos;
  assign sel_miss = (cur_op == OP_VERIFY) ? v_miss : u_miss;

  // Miss counting: one more key after a wrong one; alarm at the limit.
  assign miss_inc  = {1'b0, sel_miss} + (LW + 1)'(1);
  assign alarm     = (miss_inc >= {1'b0, LEN_MAX});
  assign step_miss = alarm ? '0 : miss_inc[LW-1:0];
  assign step_res  = alarm ? ST_ALARM : ST_CLOSED;

  // Match against the code word read in the previous cycle.
  assign pos_inc = sel_pos + LW'(1);
  assign hit     = (sel_pos < code_len) && (code_rdata == key_r);
  assign last    = (pos_inc == code_len);
  assign done_st = (op_r == OP_VERIFY) ? ST_NEW : ST_OPEN;

  // Buffer a key in enter mode unless it is a control key or the buffer is full.
  assign ent_store = in_acc && (op == OP_ENTER) && (key != KEY_CLEAR) &&
                     (key != KEY_MODE) && (key != KEY_ENTER) && (ent_len < LEN_MAX);

  assign code_we = (state == S_COPY) && wr_pend;

  klock_ram #(
    .WIDTH (8),
    .DEPTH (MAX_CODE_LEN)
  ) u_code_ram (
    .clk   (clk),
    .we    (code_we),
    .waddr (wr_idx),
    .wdata (ent_rdata),
    .raddr (sel_pos[AW-1:0]),
    .rdata (code_rdata)
  );

  assign ent_we = ent_store;

  klock_ram #(
    .WIDTH (8),
    .DEPTH (MAX_CODE_LEN)
  ) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_len[AW-1:0]),
    .wdata (key),
    .raddr (rd_idx[AW-1:0]),
    .rdata (ent_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      u_pos     <= '0;
      u_miss    <= '0;
      v_pos     <= '0;
      v_miss    <= '0;
      code_len  <= '0;
      ent_len   <= '0;
      rd_idx    <= '0;
      wr_pend   <= 1'b0;
    end else begin
      // drop the output beat once taken; the response state reloads it itself
      if (out_valid && !out_stall && state != S_RESP) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            op_r  <= op;
            key_r <= key;
            state <= S_RESP;
            case (op)
              OP_UNLOCK: begin
                if (key == KEY_CLEAR) begin
                  u_pos  <= '0;
                  u_miss <= '0;
                  res    <= ST_CLEARED;
                end else if (u_miss != '0) begin
                  u_miss <= step_miss;
                  res    <= step_res;
                end else begin
                  state  <= S_LOOK;
                end
              end
              OP_VERIFY: begin
                if (key == KEY_CLEAR || key == KEY_MODE) begin
                  v_pos  <= '0;
                  v_miss <= '0;
                  res    <= (key == KEY_CLEAR) ? ST_CLEARED : ST_MODE;
                end else if (v_miss != '0) begin
                  v_miss <= step_miss;
                  res    <= step_res;
                end else begin
                  state  <= S_LOOK;
                end
              end
              OP_ENTER: begin
                if (key == KEY_CLEAR) begin
                  ent_len <= '0;
                  res     <= ST_CLEARED;
                end else if (key == KEY_MODE) begin
                  ent_len <= '0;
                  res     <= ST_MODE;
                end else if (ent_store) begin
                  ent_len <= ent_len + LW'(1);
                  res     <= ST_SAME;
                end else begin
                  // commit: 'D', or a key arriving on a full buffer
                  rd_idx  <= '0;
                  wr_pend <= 1'b0;
                  state   <= S_COPY;
                end
              end
              default: begin
                res <= ST_CLOSED;
              end
            endcase
          end
        end
        S_LOOK: begin
          if (op_r == OP_VERIFY) begin
            v_pos  <= (hit && !last) ? pos_inc : '0;
            v_miss <= hit ? v_miss : pos_inc;
          end else begin
            u_pos  <= (hit && !last) ? pos_inc : '0;
            u_miss <= hit ? u_miss : pos_inc;
          end
          res   <= (hit && last) ? done_st : ST_CLOSED;
          state <= S_RESP;
        end
        S_COPY: begin
          // read one buffered key per cycle, write it to the code in the following cycle
          wr_pend <= (rd_idx < ent_len);
          if (rd_idx < ent_len) begin
            rd_idx <= rd_idx + LW'(1);
            wr_idx <= rd_idx[AW-1:0];
          end else if (!wr_pend) begin
            code_len <= ent_len;
            ent_len  <= '0;
            res      <= ST_CHANGED;
            state    <= S_RESP;
          end
        end
        S_RESP: begin
          // hold the status until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            status    <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // A code lookup always follows directly on an accepted beat.
  a_look_from_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK) |-> ($past(state) == S_IDLE && $past(in_acc)))
    else $error("code lookup without an accepted beat");

  // Copy never writes past the buffered length.
  a_copy_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY && wr_pend) |-> (LW'(wr_idx) < ent_len))
    else $error("commit copy write beyond buffered length");

  // Lengths stay within the memory depth.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    (code_len <= LEN_MAX) && (ent_len <= LEN_MAX))
    else $error("code or entry length beyond memory depth");

  // The output register is only loaded from the response state.
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid)) |-> ($past(state) == S_RESP))
    else $error("output beat not loaded from response state");
`endif

endmodule
